/* design/hlfr_pkg.sv */
// ----------------------------------------------------------------------------
// hlfr_pkg
// Types, constants and helper functions shared by the hex link frame receiver.
// ----------------------------------------------------------------------------
package hlfr_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned SYNC_W      = 32;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam logic [SYNC_W-1:0]  SYNC_RESET = 32'hdcc0_23c2;
    localparam logic [BYTE_W-1:0]  ACK_FLAG   = 8'h80;
    localparam logic [BYTE_W-1:0]  LAST_ID_RESET = 8'h01;

    // byte positions within the frame header
    localparam logic [COUNT_W-1:0] IDX_SYNC_END = 17'd4;
    localparam logic [COUNT_W-1:0] IDX_LEN_HI   = 17'd8;
    localparam logic [COUNT_W-1:0] IDX_LEN_LO   = 17'd9;
    localparam logic [COUNT_W-1:0] IDX_CK_HI    = 17'd10;
    localparam logic [COUNT_W-1:0] IDX_CK_LO    = 17'd11;
    localparam logic [COUNT_W-1:0] IDX_ID       = 17'd12;
    localparam logic [COUNT_W-1:0] IDX_FLAG     = 17'd13;
    localparam logic [COUNT_W-1:0] IDX_PAYLOAD  = 17'd14;

    typedef enum logic [1:0] {
        VERDICT_BAD       = 2'd0,
        VERDICT_WRONG_ID  = 2'd1,
        VERDICT_ACCEPTED  = 2'd2,
        VERDICT_DUPLICATE = 2'd3
    } t_verdict;

    typedef struct packed {
        logic              first;
        logic [BYTE_W-1:0] value;
    } t_byte_req;

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              frame_done;
        t_verdict          verdict;
        logic              ack_send;
        logic [BYTE_W-1:0] ack_id;
        logic [WORD_W-1:0] ack_checksum;
    } t_result;

    function automatic logic [3:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            n = c[3:0] + 4'd9;
        end
        return n;
    endfunction

    function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
    endfunction

endpackage

/* design/hlfr_front.sv */
// ----------------------------------------------------------------------------
// hlfr_front
// Accepts hex characters, pairs nibbles into bytes and marks frame starts.
// ----------------------------------------------------------------------------
module hlfr_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_char_valid,
    output logic                         o_char_ready,
    input  logic [hlfr_pkg::CHAR_W-1:0]  i_char,
    input  logic                         i_start,
    input  logic                         i_q_full,
    output logic                         o_push,
    output hlfr_pkg::t_byte_req          o_push_req
);

    logic       r_in_frame, n_in_frame;
    logic       r_phase, n_phase;
    logic       r_first, n_first;
    logic [3:0] r_high, n_high;
    logic [3:0] nib;
    logic       accept;

    assign o_char_ready = !i_q_full;
    assign accept       = i_char_valid && !i_q_full;
    assign nib          = hlfr_pkg::hex_nibble(i_char);

    always_comb begin
        n_in_frame       = r_in_frame;
        n_phase          = r_phase;
        n_first          = r_first;
        n_high           = r_high;
        o_push           = 1'b0;
        o_push_req.first = r_first;
        o_push_req.value = {r_high, nib};
        if (accept) begin
            if (i_start) begin
                n_in_frame = 1'b1;
                n_phase    = 1'b1;
                n_first    = 1'b1;
                n_high     = nib;
            end else if (r_in_frame) begin
                if (!r_phase) begin
                    n_phase = 1'b1;
                    n_high  = nib;
                end else begin
                    o_push  = 1'b1;
                    n_phase = 1'b0;
                    n_first = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_phase    <= 1'b0;
            r_first    <= 1'b0;
            r_high     <= 4'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_phase    <= n_phase;
            r_first    <= n_first;
            r_high     <= n_high;
        end
    end

endmodule

/* design/hlfr_queue.sv */
// ----------------------------------------------------------------------------
// hlfr_queue
// Short first-in first-out queue of byte requests between front and back.
// ----------------------------------------------------------------------------
module hlfr_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hlfr_pkg::t_byte_req i_push_req,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output hlfr_pkg::t_byte_req o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hlfr_pkg::t_byte_req r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!do_push && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

endmodule

/* design/hlfr_back.sv */
// ----------------------------------------------------------------------------
// hlfr_back
// Parses frame bytes, sums the checksum, gives the verdict and holds results.
// ----------------------------------------------------------------------------
module hlfr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [hlfr_pkg::SYNC_W-1:0]       i_cfg_wdata,
    input  logic                              i_q_valid,
    input  hlfr_pkg::t_byte_req               i_q_head,
    output logic                              o_pop,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output hlfr_pkg::t_result                 o_res
);

    localparam int unsigned BW = hlfr_pkg::BYTE_W;
    localparam int unsigned WW = hlfr_pkg::WORD_W;
    localparam int unsigned CW = hlfr_pkg::COUNT_W;

    logic [hlfr_pkg::SYNC_W-1:0] r_sync_word;
    logic [WW-1:0] r_ss1, r_ss2, r_ss3;

    logic          r_in_frame;
    logic [CW-1:0] r_byte_count;
    logic          r_sync_ok;
    logic [WW-1:0] r_frame_length;
    logic [WW-1:0] r_rx_checksum;
    logic [BW-1:0] r_frame_id;
    logic [WW-1:0] r_running_sum;
    logic [BW-1:0] r_pending;
    logic [BW-1:0] r_last_id;
    logic          r_expected_id;
    logic [WW-1:0] r_last_checksum;
    logic          r_out_valid;
    hlfr_pkg::t_result r_out;

    logic          n_in_frame;
    logic [CW-1:0] n_byte_count;
    logic          n_sync_ok;
    logic [WW-1:0] n_frame_length;
    logic [WW-1:0] n_rx_checksum;
    logic [BW-1:0] n_frame_id;
    logic [WW-1:0] n_running_sum;
    logic [BW-1:0] n_pending;
    logic [BW-1:0] n_last_id;
    logic          n_expected_id;
    logic [WW-1:0] n_last_checksum;
    logic          n_out_valid;
    hlfr_pkg::t_result n_out;

    logic          live;
    logic [CW-1:0] idx;
    logic [WW-1:0] base_sum;
    logic          base_sync_ok;
    logic [BW-1:0] b, sb, sync_byte;
    logic          is_payload, is_done;
    logic [WW-1:0] add_word, sum_new;
    logic [WW-1:0] ack_ck;
    hlfr_pkg::t_verdict verdict;

    assign o_pop       = i_q_valid && (!r_out_valid || i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    assign b            = i_q_head.value;
    assign live         = i_q_head.first || r_in_frame;
    assign idx          = i_q_head.first ? '0 : r_byte_count;
    assign base_sum     = i_q_head.first ? '0 : r_running_sum;
    assign base_sync_ok = i_q_head.first ? 1'b1 : r_sync_ok;
    assign sb           = (idx == hlfr_pkg::IDX_CK_HI || idx == hlfr_pkg::IDX_CK_LO) ? '0 : b;
    assign is_payload   = (idx >= hlfr_pkg::IDX_PAYLOAD);
    assign is_done      = (idx >= hlfr_pkg::IDX_FLAG)
                       && (idx == hlfr_pkg::IDX_FLAG + {1'b0, r_frame_length});
    assign add_word     = idx[0] ? {r_pending, sb} : {sb, {BW{1'b0}}};
    assign sum_new      = hlfr_pkg::ones_add(base_sum, add_word);
    assign ack_ck       = ~hlfr_pkg::ones_add(r_ss3, {r_frame_id, hlfr_pkg::ACK_FLAG});

    always_comb begin
        case (idx[1:0])
            2'd0:    sync_byte = r_sync_word[31:24];
            2'd1:    sync_byte = r_sync_word[23:16];
            2'd2:    sync_byte = r_sync_word[15:8];
            default: sync_byte = r_sync_word[7:0];
        endcase
    end

    always_comb begin
        if (!r_sync_ok || r_rx_checksum != ~sum_new) begin
            verdict = hlfr_pkg::VERDICT_BAD;
        end else if (r_frame_id == r_last_id && r_rx_checksum == r_last_checksum) begin
            verdict = hlfr_pkg::VERDICT_DUPLICATE;
        end else if (r_frame_id != {{(BW-1){1'b0}}, r_expected_id}) begin
            verdict = hlfr_pkg::VERDICT_WRONG_ID;
        end else begin
            verdict = hlfr_pkg::VERDICT_ACCEPTED;
        end
    end

    always_comb begin
        n_in_frame      = r_in_frame;
        n_byte_count    = r_byte_count;
        n_sync_ok       = r_sync_ok;
        n_frame_length  = r_frame_length;
        n_rx_checksum   = r_rx_checksum;
        n_frame_id      = r_frame_id;
        n_running_sum   = r_running_sum;
        n_pending       = r_pending;
        n_last_id       = r_last_id;
        n_expected_id   = r_expected_id;
        n_last_checksum = r_last_checksum;
        n_out_valid     = r_out_valid && !i_res_ready;
        n_out           = r_out;

        if (o_pop && live) begin
            n_in_frame    = 1'b1;
            n_byte_count  = idx + 1'b1;
            n_sync_ok     = base_sync_ok;
            n_running_sum = base_sum;
            if (idx < hlfr_pkg::IDX_SYNC_END && b != sync_byte) begin
                n_sync_ok = 1'b0;
            end
            case (idx)
                hlfr_pkg::IDX_LEN_HI: n_frame_length = {b, {BW{1'b0}}};
                hlfr_pkg::IDX_LEN_LO: n_frame_length = {r_frame_length[WW-1:BW], b};
                hlfr_pkg::IDX_CK_HI:  n_rx_checksum  = {b, {BW{1'b0}}};
                hlfr_pkg::IDX_CK_LO:  n_rx_checksum  = {r_rx_checksum[WW-1:BW], b};
                hlfr_pkg::IDX_ID:     n_frame_id     = b;
                default: ;
            endcase
            if (idx[0] || is_done) begin
                n_running_sum = sum_new;
            end
            if (!idx[0]) begin
                n_pending = sb;
            end

            if (is_payload || is_done) begin
                n_out_valid         = 1'b1;
                n_out.payload_valid = is_payload;
                n_out.payload_byte  = is_payload ? b : '0;
                n_out.frame_done    = is_done;
                n_out.verdict       = is_done ? verdict : hlfr_pkg::VERDICT_BAD;
                n_out.ack_send      = 1'b0;
                n_out.ack_id        = '0;
                n_out.ack_checksum  = '0;
                if (is_done) begin
                    n_in_frame = 1'b0;
                    if (verdict == hlfr_pkg::VERDICT_ACCEPTED) begin
                        n_last_id       = r_frame_id;
                        n_last_checksum = r_rx_checksum;
                        n_expected_id   = !r_expected_id;
                    end
                    if (verdict == hlfr_pkg::VERDICT_ACCEPTED
                        || verdict == hlfr_pkg::VERDICT_DUPLICATE) begin
                        n_out.ack_send     = 1'b1;
                        n_out.ack_id       = r_frame_id;
                        n_out.ack_checksum = ack_ck;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_word     <= hlfr_pkg::SYNC_RESET;
            r_in_frame      <= 1'b0;
            r_byte_count    <= '0;
            r_last_id       <= hlfr_pkg::LAST_ID_RESET;
            r_expected_id   <= 1'b0;
            r_last_checksum <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_sync_word <= i_cfg_wdata;
            end
            r_in_frame      <= n_in_frame;
            r_byte_count    <= n_byte_count;
            r_last_id       <= n_last_id;
            r_expected_id   <= n_expected_id;
            r_last_checksum <= n_last_checksum;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ss1          <= hlfr_pkg::ones_add(r_sync_word[31:16], r_sync_word[15:0]);
        r_ss2          <= hlfr_pkg::ones_add(r_ss1, r_sync_word[31:16]);
        r_ss3          <= hlfr_pkg::ones_add(r_ss2, r_sync_word[15:0]);
        r_sync_ok      <= n_sync_ok;
        r_frame_length <= n_frame_length;
        r_rx_checksum  <= n_rx_checksum;
        r_frame_id     <= n_frame_id;
        r_running_sum  <= n_running_sum;
        r_pending      <= n_pending;
        r_out          <= n_out;
    end

endmodule

/* design/hex_link_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// hex_link_frame_receiver_unit
// Receives hex-encoded link frames, streams payload and reports the verdict.
// ----------------------------------------------------------------------------
// Takes one hex character per cycle while the queue has room. The front pairs
// characters into bytes and hands them through a QUEUE_DEPTH-entry queue to the
// back, which parses the header, keeps the ones'-complement sum and, on the last
// byte, gives the verdict and the acknowledgement request in the same cycle as
// one word add and compare. s_axis_tready falls only while the queue is full,
// which happens only when the result side stalls. Each byte is written to
// the queue when the character completing it is accepted, and its result is
// registered in the back when it is popped. Acknowledgement checksums follow
// a new sync word once the write has passed through r_ss1, r_ss2 and r_ss3.
module hex_link_frame_receiver_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hlfr_pkg::SYNC_W-1:0]         i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [hlfr_pkg::CHAR_W-1:0]         s_axis_tdata,   // [7:0] link_char
    input  logic                                s_axis_tuser,   // [0] frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [7:0] payload_byte, [9:8] verdict, [10] ack_send, [18:11] ack_id,
    // [34:19] ack_checksum, [39:35] zero
    output logic [hlfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                                m_axis_tlast,   // frame_done
    output logic                                m_axis_tuser    // [0] payload_valid
);

    localparam int unsigned PAD_W = hlfr_pkg::OUT_TDATA_W - hlfr_pkg::WORD_W
                                  - 2 * hlfr_pkg::BYTE_W - 3;

    logic                push, q_full, q_valid, pop;
    hlfr_pkg::t_byte_req push_req, q_head;
    hlfr_pkg::t_result   res;

    hlfr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (s_axis_tvalid),
        .o_char_ready (s_axis_tready),
        .i_char       (s_axis_tdata),
        .i_start      (s_axis_tuser),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_req   (push_req)
    );

    hlfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    hlfr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_head    (q_head),
        .o_pop       (pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, res.ack_checksum, res.ack_id, res.ack_send,
                           res.verdict, res.payload_byte};
    assign m_axis_tlast = res.frame_done;
    assign m_axis_tuser = res.payload_valid;

endmodule

/* design/hlfr_checker.sv */
// ----------------------------------------------------------------------------
// hlfr_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module hlfr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [hlfr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                             m_axis_tlast,
    input logic                             m_axis_tuser
);

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request shown right after reset");

    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast)
                                            && $stable(m_axis_tuser))
        else $error("stalled result request changed");

    a_has_content : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser || m_axis_tlast)
        else $error("result request carries neither payload nor frame end");

    a_ack_rule : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[10] == (m_axis_tlast && m_axis_tdata[9]))
        else $error("acknowledgement flag disagrees with verdict");

    a_zero_fields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[39:8] == '0)
        else $error("frame-end fields set on a payload-only result");

endmodule

bind hex_link_frame_receiver_unit hlfr_checker u_hlfr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
